### design/hscm_pkg.sv
package hscm_pkg;

  localparam int CountBits    = 32;
  localparam int CfgIndexBits = 2;
  localparam int CfgDataBits  = 32;
  localparam int LogFracBits  = 16;

  typedef enum logic [CfgIndexBits-1:0] {
    REG_MAX_COUNT = 2'd0,
    REG_LOG_SCALE = 2'd1,
    REG_ALPHA     = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic valid;
    logic zero;
    logic sat;
  } hscm_tag_t;

  function automatic logic [16:0] log_tab(input logic [5:0] k);
    logic [16:0] v;
    case (k)
      6'd0:  v = 17'd0;
      6'd1:  v = 17'd2909;
      6'd2:  v = 17'd5732;
      6'd3:  v = 17'd8473;
      6'd4:  v = 17'd11136;
      6'd5:  v = 17'd13727;
      6'd6:  v = 17'd16248;
      6'd7:  v = 17'd18704;
      6'd8:  v = 17'd21098;
      6'd9:  v = 17'd23433;
      6'd10: v = 17'd25711;
      6'd11: v = 17'd27936;
      6'd12: v = 17'd30109;
      6'd13: v = 17'd32234;
      6'd14: v = 17'd34312;
      6'd15: v = 17'd36346;
      6'd16: v = 17'd38336;
      6'd17: v = 17'd40286;
      6'd18: v = 17'd42196;
      6'd19: v = 17'd44068;
      6'd20: v = 17'd45904;
      6'd21: v = 17'd47705;
      6'd22: v = 17'd49472;
      6'd23: v = 17'd51207;
      6'd24: v = 17'd52911;
      6'd25: v = 17'd54584;
      6'd26: v = 17'd56229;
      6'd27: v = 17'd57845;
      6'd28: v = 17'd59434;
      6'd29: v = 17'd60997;
      6'd30: v = 17'd62534;
      6'd31: v = 17'd64047;
      6'd32: v = 17'd65536;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] palette(input logic [2:0] seg, input logic [1:0] ch);
    logic [23:0] rgb;
    logic [7:0]  c;
    case (seg)
      3'd0:    rgb = 24'h440154;
      3'd1:    rgb = 24'h3b528b;
      3'd2:    rgb = 24'h21918c;
      3'd3:    rgb = 24'h5ec962;
      3'd4:    rgb = 24'hfde725;
      default: rgb = 24'h000000;
    endcase
    case (ch)
      2'd0:    c = rgb[23:16];
      2'd1:    c = rgb[15:8];
      default: c = rgb[7:0];
    endcase
    return c;
  endfunction

endpackage

### design/hscm_log.sv
module hscm_log #(
  parameter int YW = 33,
  parameter int LW = 22
) (
  input  logic          clk,
  input  logic [YW-2:0] x,
  output logic [LW-1:0] lval
);
  import hscm_pkg::*;

  localparam int PW = $clog2(YW);

  logic [YW-1:0]    y_next;
  logic [YW-1:0]    y1;
  logic [PW-1:0]    p_next;
  logic [PW-1:0]    p1;
  logic [PW-1:0]    p2;
  logic [YW+15:0]   z;
  logic [4:0]       idx2;
  logic [10:0]      r2;
  logic [16:0]      lo;
  logic [16:0]      hi;
  logic [16:0]      diff;
  logic [22:0]      prod;
  logic [LW-1:0]    lval_next;

  always_comb begin
    y_next = {1'b0, x} + YW'(1);
    p_next = '0;
    for (int i = 0; i < YW; i++) begin
      if (y_next[i]) begin
        p_next = PW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    y1 <= y_next;
    p1 <= p_next;
  end

  assign z = {y1, 16'b0} << (PW'(YW - 1) - p1);

  always_ff @(posedge clk) begin
    idx2 <= z[YW+14 -: 5];
    r2   <= z[YW+9 -: 11];
    p2   <= p1;
  end

  always_comb begin
    lo        = log_tab({1'b0, idx2});
    hi        = log_tab({1'b0, idx2} + 6'd1);
    diff      = hi - lo;
    prod      = diff[11:0] * r2;
    lval_next = LW'({p2, 16'b0}) + LW'(lo) + LW'(prod[22:11]);
  end

  always_ff @(posedge clk) begin
    lval <= lval_next;
  end

endmodule

### design/hscm_div.sv
module hscm_div #(
  parameter int DW = 33,
  parameter int FB = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  hscm_pkg::hscm_tag_t tag_in,
  input  logic [DW-1:0]       num_in,
  input  logic [DW-1:0]       den_in,
  output hscm_pkg::hscm_tag_t tag_out,
  output logic [FB-1:0]       q_out
);
  import hscm_pkg::*;

  hscm_tag_t     tag_s [0:FB];
  logic [DW-1:0] rem_s [0:FB];
  logic [DW-1:0] den_s [0:FB];
  logic [FB-1:0] q_s   [0:FB];

  assign tag_s[0] = tag_in;
  assign rem_s[0] = num_in;
  assign den_s[0] = den_in;
  assign q_s[0]   = '0;

  for (genvar i = 0; i < FB; i++) begin : g_step
    logic [DW:0] r2;
    logic        ge;

    assign r2 = {rem_s[i], 1'b0};
    assign ge = (r2 >= {1'b0, den_s[i]});

    always_ff @(posedge clk) begin
      if (rst) begin
        tag_s[i+1] <= '0;
      end else begin
        tag_s[i+1] <= tag_s[i];
      end
      rem_s[i+1] <= ge ? DW'(r2 - {1'b0, den_s[i]}) : DW'(r2);
      den_s[i+1] <= den_s[i];
      q_s[i+1]   <= {q_s[i][FB-2:0], ge};
    end
  end

  assign tag_out = tag_s[FB];
  assign q_out   = q_s[FB];

endmodule

### design/hscm_lerp.sv
module hscm_lerp #(
  parameter int FB = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  hscm_pkg::hscm_tag_t tag_in,
  input  logic [FB-1:0]       q_in,
  input  logic [7:0]          alpha,
  output logic                done,
  output logic [7:0]          red,
  output logic [7:0]          green,
  output logic [7:0]          blue,
  output logic [7:0]          opacity
);
  import hscm_pkg::*;

  localparam int VW = FB + 11;

  logic [FB:0]   amt;
  logic [1:0]    seg_next;
  logic [FB+2:0] tfull;
  hscm_tag_t     tag1;
  logic [1:0]    seg1;
  logic [FB:0]   t1;
  logic [7:0]    chan [0:2];

  always_comb begin
    amt = tag_in.sat ? (FB+1)'(1) << FB : {1'b0, q_in};
    seg_next = amt[FB] ? 2'd3 : amt[FB-1:FB-2];
    tfull = {amt, 2'b0} - {1'b0, seg_next, {FB{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1 <= '0;
    end else begin
      tag1 <= tag_in;
    end
    seg1 <= seg_next;
    t1   <= tfull[FB:0];
  end

  for (genvar c = 0; c < 3; c++) begin : g_chan
    logic [7:0]          left;
    logic [7:0]          right;
    logic signed [8:0]   diff;
    logic signed [VW-1:0] v;

    always_comb begin
      left  = palette({1'b0, seg1}, 2'(c));
      right = palette({1'b0, seg1} + 3'd1, 2'(c));
      diff  = $signed({1'b0, right}) - $signed({1'b0, left});
      v     = $signed({3'b0, left, {FB{1'b0}}})
            + VW'(diff) * VW'($signed({1'b0, t1}))
            + $signed(VW'(1) << (FB - 1));
    end

    assign chan[c] = v[FB+7:FB];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= tag1.valid;
    end
    if (tag1.zero) begin
      red     <= '0;
      green   <= '0;
      blue    <= '0;
      opacity <= '0;
    end else begin
      red     <= chan[0];
      green   <= chan[1];
      blue    <= chan[2];
      opacity <= alpha;
    end
  end

endmodule

### design/heat_scale_colour_map.sv
// Heat colour map: turns a support count into an RGBA colour on five
// Viridis anchors, scaled linearly or logarithmically against max_count.
// Input: raise start with count; the beat is taken at every clock edge where
// start is high and busy is low. busy stays low, so a count may enter on
// every clock.
// Output: done is high for one cycle with red, green, blue and opacity; the
// receiver cannot stall, so every result is shown exactly once.
// Configuration: a write beat on cfg_valid and cfg_ready sets the register
// at cfg_index (0 max_count, 1 log_scale, 2 alpha_value) from cfg_data;
// other indexes are ignored. Write only while no count is in flight.
// Throughput is one colour per clock. The input register loads at the
// accepting edge; three logarithm stages, one restoring division step
// per fraction bit and two interpolation stages follow it.
// Reset clears the pipeline valid bits and loads max_count 0, log_scale 0
// and alpha_value 255.
module heat_scale_colour_map #(
  parameter int COUNT_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [hscm_pkg::CountBits-1:0]   count,
  output logic                             done,
  output logic [7:0]                       red,
  output logic [7:0]                       green,
  output logic [7:0]                       blue,
  output logic [7:0]                       opacity,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [hscm_pkg::CfgIndexBits-1:0] cfg_index,
  input  logic [hscm_pkg::CfgDataBits-1:0] cfg_data
);
  import hscm_pkg::*;

  localparam int EW = (COUNT_WIDTH < CountBits) ? COUNT_WIDTH : CountBits;
  localparam int YW = EW + 1;
  localparam int LW = $clog2(YW + 1) + LogFracBits;
  localparam int DW = (EW > LW) ? EW : LW;

  logic [CountBits-1:0] max_count;
  logic                 log_scale;
  logic [7:0]           alpha_value;

  logic [EW-1:0] cnt_in;
  logic [EW-1:0] mx;
  hscm_tag_t     tag_next;
  hscm_tag_t     tag0;
  logic [EW-1:0] c0;
  hscm_tag_t     tag_d [1:3];
  logic [EW-1:0] c_d   [1:3];
  logic [LW-1:0] lcnt;
  logic [LW-1:0] lmax;
  logic [DW-1:0] num;
  logic [DW-1:0] den;
  hscm_tag_t     tag_q;
  logic [FRAC_BITS-1:0] q;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_count   <= '0;
      log_scale   <= 1'b0;
      alpha_value <= 8'd255;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MAX_COUNT: max_count   <= cfg_data;
        REG_LOG_SCALE: log_scale   <= cfg_data[0];
        REG_ALPHA:     alpha_value <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign cnt_in = count[EW-1:0];
  assign mx     = max_count[EW-1:0];

  always_comb begin
    tag_next.valid = start && !busy;
    tag_next.zero  = (cnt_in == '0) || (mx == '0);
    tag_next.sat   = (mx == EW'(1)) || (cnt_in >= mx);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag0 <= '0;
    end else begin
      tag0 <= tag_next;
    end
    c0 <= cnt_in;
  end

  hscm_log #(.YW(YW), .LW(LW)) u_log_cnt (
    .clk  (clk),
    .x    (c0),
    .lval (lcnt)
  );

  hscm_log #(.YW(YW), .LW(LW)) u_log_max (
    .clk  (clk),
    .x    (mx),
    .lval (lmax)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_d[1] <= '0;
      tag_d[2] <= '0;
      tag_d[3] <= '0;
    end else begin
      tag_d[1] <= tag0;
      tag_d[2] <= tag_d[1];
      tag_d[3] <= tag_d[2];
    end
    c_d[1] <= c0;
    c_d[2] <= c_d[1];
    c_d[3] <= c_d[2];
  end

  assign num = log_scale ? DW'(lcnt) : DW'(c_d[3]);
  assign den = log_scale ? DW'(lmax) : DW'(mx);

  hscm_div #(.DW(DW), .FB(FRAC_BITS)) u_div (
    .clk     (clk),
    .rst     (rst),
    .tag_in  (tag_d[3]),
    .num_in  (num),
    .den_in  (den),
    .tag_out (tag_q),
    .q_out   (q)
  );

  hscm_lerp #(.FB(FRAC_BITS)) u_lerp (
    .clk     (clk),
    .rst     (rst),
    .tag_in  (tag_q),
    .q_in    (q),
    .alpha   (alpha_value),
    .done    (done),
    .red     (red),
    .green   (green),
    .blue    (blue),
    .opacity (opacity)
  );

endmodule
